>>> src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked at every rising edge outside reset
`define CHK_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked at every rising edge outside reset
`define CHK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/crc32rc_pkg.sv
package crc32rc_pkg;

    // size of the storage region that holds one record
    localparam int unsigned REGION_BYTES = 4096;
    // header and crc take sixteen bytes of the region
    localparam logic [31:0] MAX_PAYLOAD  = 32'(REGION_BYTES - 16);

    localparam int unsigned POS_W  = 13;
    localparam int unsigned SIZE_W = 12;
    localparam logic [POS_W-1:0] HDR_BYTES = POS_W'(12);

    localparam logic [31:0] CRC_POLY      = 32'hEDB8_8320;
    localparam logic [31:0] ALL_ONES      = 32'hFFFF_FFFF;
    // default magic of the parameter record ("BPAP" little-endian)
    localparam logic [31:0] DEFAULT_MAGIC = 32'h5041_5042;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_MAGIC        = 3'd0,
        REG_VERSION      = 3'd1,
        REG_SIZE_BOUND   = 3'd2,
        REG_EXACT_SIZE   = 3'd3,
        REG_OUT_CAPACITY = 3'd4
    } reg_index_t;

    // closing status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_CORRUPT   = 2'd2,
        ST_TOO_LARGE = 2'd3
    } status_t;

    typedef struct packed {
        logic [31:0]       magic;
        logic [31:0]       version;
        logic [SIZE_W-1:0] size_bound;
        logic              exact_size;
        logic [SIZE_W-1:0] out_capacity;
    } cfg_t;

    typedef struct packed {
        logic [7:0]        out_byte;
        logic              is_payload;
        logic              is_status;
        status_t           status;
        logic [SIZE_W-1:0] payload_length;
    } result_t;

    // reflected crc-32, one byte, eight bit steps unrolled
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc_in,
                                               input logic [7:0]  data_in);
        logic [31:0] c;
        c = crc_in ^ {24'd0, data_in};
        for (int i = 0; i < 8; i++) begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
        end
        return c;
    endfunction

endpackage

>>> src/crc32rc_cfg.sv
module crc32rc_cfg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    output crc32rc_pkg::cfg_t   cfg
);

    crc32rc_pkg::cfg_t cfg_reg;
    crc32rc_pkg::cfg_t cfg_next;

    // register write decode, unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (crc32rc_pkg::reg_index_t'(cfg_index))
                crc32rc_pkg::REG_MAGIC:
                    cfg_next.magic = cfg_data;
                crc32rc_pkg::REG_VERSION:
                    cfg_next.version = cfg_data;
                crc32rc_pkg::REG_SIZE_BOUND:
                    cfg_next.size_bound = cfg_data[crc32rc_pkg::SIZE_W-1:0];
                crc32rc_pkg::REG_EXACT_SIZE:
                    cfg_next.exact_size = cfg_data[0];
                crc32rc_pkg::REG_OUT_CAPACITY:
                    cfg_next.out_capacity = cfg_data[crc32rc_pkg::SIZE_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    // register bank
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.magic        <= crc32rc_pkg::DEFAULT_MAGIC;
            cfg_reg.version      <= 32'd1;
            cfg_reg.size_bound   <= crc32rc_pkg::SIZE_W'(crc32rc_pkg::MAX_PAYLOAD);
            cfg_reg.exact_size   <= 1'b0;
            cfg_reg.out_capacity <= crc32rc_pkg::SIZE_W'(crc32rc_pkg::MAX_PAYLOAD);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> src/crc32rc_frame.sv
module crc32rc_frame (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             data_byte,
    input  logic                   record_start,
    input  crc32rc_pkg::cfg_t      cfg,
    input  logic                   out_free,
    output logic                   res_valid,
    output crc32rc_pkg::result_t   res
);

    localparam int unsigned POS_W  = crc32rc_pkg::POS_W;
    localparam int unsigned SIZE_W = crc32rc_pkg::SIZE_W;

    // input register
    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic [7:0]  data_reg;
    logic        start_reg;

    // record state
    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_next;
    logic [31:0]       crc_reg;
    logic [31:0]       crc_next;
    logic [23:0]       lo_reg;
    logic [23:0]       lo_next;
    logic [SIZE_W-1:0] size_reg;
    logic [SIZE_W-1:0] size_next;
    logic              done_reg;
    logic              done_next;

    logic              consume;
    logic              active;
    logic [POS_W-1:0]  pos_cur;
    logic [31:0]       crc_cur;
    logic [31:0]       crc_upd;
    logic [31:0]       word_full;
    logic [POS_W-1:0]  payload_end;
    logic [1:0]        sel;
    logic [23:0]       lo_upd;
    logic              passes;
    logic              size_bad;
    logic              fire;
    crc32rc_pkg::result_t res_c;

    assign consume  = s1_valid_reg && out_free;
    assign in_ready = !s1_valid_reg || out_free;

    // a start restarts the record with this word
    assign active      = start_reg || !done_reg;
    assign pos_cur     = start_reg ? '0 : pos_reg;
    assign crc_cur     = start_reg ? crc32rc_pkg::ALL_ONES : crc_reg;
    assign crc_upd     = crc32rc_pkg::crc32_byte(crc_cur, data_reg);
    assign word_full   = {data_reg, lo_reg};
    assign payload_end = crc32rc_pkg::HDR_BYTES + POS_W'(size_reg);
    assign passes      = cfg.exact_size || (size_reg <= cfg.out_capacity);

    // byte lane within the current little-endian word
    always_comb
    begin
        if (pos_cur < crc32rc_pkg::HDR_BYTES)
        begin
            sel = pos_cur[1:0];
        end
        else
        begin
            sel = pos_cur[1:0] - payload_end[1:0];
        end
        lo_upd = lo_reg;
        case (sel)
            2'd0:    lo_upd = {16'd0, data_reg};
            2'd1:    lo_upd[15:8] = data_reg;
            2'd2:    lo_upd[23:16] = data_reg;
            default: lo_upd = lo_reg;
        endcase
    end

    // size check against limit and region
    always_comb
    begin
        if (cfg.exact_size)
        begin
            size_bad = (word_full != {20'd0, cfg.size_bound}) ||
                       (word_full > crc32rc_pkg::MAX_PAYLOAD);
        end
        else
        begin
            size_bad = (word_full > {20'd0, cfg.size_bound}) ||
                       (word_full > crc32rc_pkg::MAX_PAYLOAD);
        end
    end

    // record parser
    always_comb
    begin
        pos_next  = pos_reg;
        crc_next  = crc_reg;
        lo_next   = lo_reg;
        size_next = size_reg;
        done_next = done_reg;
        fire      = 1'b0;
        res_c     = '0;
        if (active)
        begin
            done_next = 1'b0;
            pos_next  = pos_cur + POS_W'(1);
            lo_next   = lo_upd;
            if (pos_cur < crc32rc_pkg::HDR_BYTES)
            begin
                crc_next = crc_upd;
                if (pos_cur == POS_W'(3))
                begin
                    if (word_full == crc32rc_pkg::ALL_ONES)
                    begin
                        fire         = 1'b1;
                        res_c.status = crc32rc_pkg::ST_NOT_FOUND;
                    end
                    else if (word_full != cfg.magic)
                    begin
                        fire         = 1'b1;
                        res_c.status = crc32rc_pkg::ST_CORRUPT;
                    end
                end
                else if (pos_cur == POS_W'(7))
                begin
                    if (word_full != cfg.version)
                    begin
                        fire         = 1'b1;
                        res_c.status = crc32rc_pkg::ST_CORRUPT;
                    end
                end
                else if (pos_cur == POS_W'(11))
                begin
                    size_next = word_full[SIZE_W-1:0];
                    if (size_bad)
                    begin
                        fire         = 1'b1;
                        res_c.status = crc32rc_pkg::ST_CORRUPT;
                    end
                end
            end
            else if (pos_cur < payload_end)
            begin
                // payload word, passed on in exact-size mode or when the size is within capacity
                crc_next = crc_upd;
                if (passes)
                begin
                    fire             = 1'b1;
                    res_c.out_byte   = data_reg;
                    res_c.is_payload = 1'b1;
                end
            end
            else if (sel == 2'd3)
            begin
                // last crc word closes the record
                fire = 1'b1;
                if ((crc_cur ^ crc32rc_pkg::ALL_ONES) != word_full)
                begin
                    res_c.status = crc32rc_pkg::ST_CORRUPT;
                end
                else if (!passes)
                begin
                    res_c.status = crc32rc_pkg::ST_TOO_LARGE;
                end
                else
                begin
                    res_c.status         = crc32rc_pkg::ST_OK;
                    res_c.payload_length = size_reg;
                end
            end
            if (fire && !res_c.is_payload)
            begin
                res_c.is_status = 1'b1;
                done_next       = 1'b1;
            end
        end
    end

    // input stage handshake
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_valid && in_ready)
        begin
            s1_valid_next = 1'b1;
        end
        else if (consume)
        begin
            s1_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            pos_reg      <= '0;
            crc_reg      <= crc32rc_pkg::ALL_ONES;
            size_reg     <= '0;
            done_reg     <= 1'b1;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (consume)
            begin
                pos_reg  <= pos_next;
                crc_reg  <= crc_next;
                size_reg <= size_next;
                done_reg <= done_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg  <= data_byte;
            start_reg <= record_start;
        end
        if (consume)
        begin
            lo_reg <= lo_next;
        end
    end

    assign res_valid = s1_valid_reg && fire;
    assign res       = res_c;

endmodule

>>> src/crc32_record_checker.sv
// CRC-32 framed record checker. Takes a stored record one byte per word on
// the input channel, starting at the word with record_start set: a 12-byte
// little-endian header (magic, version, payload size), the payload, then a
// little-endian reflected CRC-32 over header and payload. Payload bytes come
// out as they arrive when exact_size is set or the size fits out_capacity,
// and one status word (ok with length, not_found, corrupt, too_large) closes
// each record; words between records are dropped. One word is accepted every
// clock cycle while the output channel is not stalled; each passes an input
// register and then a result register. The cycle time is set by the byte-wide
// CRC update, eight bit steps unrolled in front of the record state registers.
// Configuration is written through cfg_we, cfg_index and cfg_data; the user
// must write it only while no record is in flight, as the block does not
// enforce it. A fixed-size record such as a calibration record uses exact_size.
`include "assert_macros.svh"

module crc32_record_checker (
    input  logic         clk,
    input  logic         rst_n,
    // configuration
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    // input channel
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [7:0]   data_byte,
    input  logic         record_start,
    // output channel
    output logic         out_valid,
    input  logic         out_ready,
    output logic [7:0]   out_byte,
    output logic         is_payload,
    output logic         is_status,
    output logic [1:0]   status,
    output logic [11:0]  payload_length
);

    crc32rc_pkg::cfg_t    cfg;
    crc32rc_pkg::result_t res;
    crc32rc_pkg::result_t res_reg;
    logic                 res_valid;
    logic                 out_free;
    logic                 out_valid_reg;
    logic                 out_valid_next;

    // configuration registers
    crc32rc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // record parser with input register
    crc32rc_frame u_frame (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .record_start (record_start),
        .cfg          (cfg),
        .out_free     (out_free),
        .res_valid    (res_valid),
        .res          (res)
    );

    // result register
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_free ? res_valid : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && res_valid)
        begin
            res_reg <= res;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_byte       = res_reg.out_byte;
    assign is_payload     = res_reg.is_payload;
    assign is_status      = res_reg.is_status;
    assign status         = res_reg.status;
    assign payload_length = res_reg.payload_length;

    // checks
    `CHK_IMPLIES(a_kind_onehot, out_valid, is_payload != is_status, "result kind not exclusive")
    `CHK_IMPLIES(a_payload_clean, out_valid && is_payload, (status == crc32rc_pkg::ST_OK) && (payload_length == 12'd0), "payload word carries status fields")
    `CHK_IMPLIES(a_fail_no_len, out_valid && is_status && (status != crc32rc_pkg::ST_OK), (payload_length == 12'd0) && (out_byte == 8'd0), "failed status carries data")
    `CHK_NEXT(a_stall_holds, !in_ready, out_valid, "input stalled without a pending result")

endmodule
